>>> sv/link_health_alarm_debouncer_core_assert.svh
// assertion macros for the link health alarm debouncer
`ifndef LINK_HEALTH_ALARM_DEBOUNCER_CORE_ASSERT_SVH
`define LINK_HEALTH_ALARM_DEBOUNCER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication under reset
`define LHAD_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lhad assertion failed");
// next-cycle implication under reset
`define LHAD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lhad assertion failed");
`else
`define LHAD_ASSERT_IMPL(label, clk, rst_n, a, b)
`define LHAD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> sv/lhad_pkg.sv
// shared types, codes and constants of the link health alarm debouncer
package lhad_pkg;

    localparam int CFG_W     = 27;
    localparam int TIME_W    = 32;
    localparam int LEFT_W    = 23;
    localparam int MINS_W    = 11;
    localparam int CFG_IDX_W = 3;

    // word kinds
    localparam logic [1:0] KIND_PROBE       = 2'd0;
    localparam logic [1:0] KIND_PAUSE_TIMED = 2'd1;
    localparam logic [1:0] KIND_PAUSE_HOLD  = 2'd2;
    localparam logic [1:0] KIND_RESUME      = 2'd3;

    // probe outcomes, anything above primary failed counts as all failed
    localparam logic [1:0] PROBE_OK       = 2'd0;
    localparam logic [1:0] PROBE_PRI_FAIL = 2'd1;

    // alarm codes
    localparam logic [1:0] ALARM_NONE      = 2'd0;
    localparam logic [1:0] ALARM_DOWN      = 2'd1;
    localparam logic [1:0] ALARM_RECOVERED = 2'd2;
    localparam logic [1:0] ALARM_CRITICAL  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OUTAGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_DST = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_FAIL_LIMIT = 27'd300000;
    localparam logic [CFG_W-1:0] RST_REPEAT_IVL = 27'd1800000;
    localparam logic [CFG_W-1:0] RST_STABLE_THR = 27'd300000;
    localparam logic [CFG_W-1:0] RST_MIN_OUTAGE = 27'd60000;

    // pause length
    localparam logic [MINS_W-1:0] MAX_PAUSE_MIN = 11'd1440;
    localparam logic [15:0]       MS_PER_MIN    = 16'd60000;

    // x / 1000 as (x >> 3) / 125, the latter by reciprocal multiply
    localparam int               DIV_PRE_SHIFT = 3;
    localparam int               DIV_N_W       = TIME_W - DIV_PRE_SHIFT;
    localparam int               DIV_M_W       = 30;
    localparam int               DIV_SHIFT     = 36;
    localparam logic [DIV_M_W-1:0] DIV_RECIP   = 30'd549755814;

    typedef struct packed {
        logic [CFG_W-1:0] fail_limit;
        logic [CFG_W-1:0] repeat_ivl;
        logic [CFG_W-1:0] stable_thr;
        logic [CFG_W-1:0] min_outage;
        logic             servers_distinct;
    } t_cfg;

    typedef struct packed {
        logic              outage_reported;
        logic [TIME_W-1:0] first_fail;
        logic [TIME_W-1:0] last_alarm;
        logic [TIME_W-1:0] stable_since;
        logic              pause_active;
        logic [TIME_W-1:0] pause_end;
        logic              working;
    } t_state;

    typedef struct packed {
        logic [1:0]        alarm;
        logic [TIME_W-1:0] duration;
        logic              working;
        logic              paused;
        logic [TIME_W-1:0] pause_diff;
    } t_result;

endpackage

>>> sv/link_health_alarm_debouncer_core.sv
// top level of the link health alarm debouncer: registers, pipeline and handshakes
`include "link_health_alarm_debouncer_core_assert.svh"

// Takes one word per clock cycle, back to back, while the output side keeps up, and
// returns one result word per input word; the result is registered in the middle
// stage at acceptance and then in the output register.
// The debounce state is updated in a single registered pass at acceptance, so a
// word sees everything left by the word before it; the middle stage feeds the
// constant multiplier that turns the remaining pause time into seconds. The middle
// stage takes one more word while a result waits in the output register, after
// which the input stalls until the output side takes a word. Configuration
// registers are written through their own channel, which is always ready, and
// take effect for the next word.
module link_health_alarm_debouncer_core import lhad_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input words
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [47:0]          i_s_axis_tdata,  // now_ms[31:0], probe_code[33:32],
                                                  // pause_minutes[44:34], zeros
    input  logic [1:0]           i_s_axis_tuser,  // kind[1:0]
    // result words
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [63:0]          o_m_axis_tdata,  // alarm_duration_ms[31:0],
                                                  // link_working[32], paused_now[33],
                                                  // pause_left_s[56:34], zeros
    output logic [1:0]           o_m_axis_tuser   // alarm[1:0]
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_s1_res;
    t_result r_s1_res;
    logic    r_s1_valid;
    logic    r_out_valid;
    logic [1:0]        r_out_alarm;
    logic [TIME_W-1:0] r_out_duration;
    logic              r_out_working;
    logic              r_out_paused;
    logic [LEFT_W-1:0] r_out_left;

    logic in_accept;
    logic out_en;
    logic s1_en;
    logic [DIV_N_W-1:0]         div_n;
    logic [DIV_N_W+DIV_M_W-1:0] div_prod;
    logic [LEFT_W-1:0]          n_out_left;

    // stage enables, each stage moves when the one after it frees up
    assign out_en          = !r_out_valid || i_m_axis_tready;
    assign s1_en           = !r_s1_valid || out_en;
    assign o_s_axis_tready = s1_en;
    assign in_accept       = i_s_axis_tvalid && s1_en;
    assign o_cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_limit       <= RST_FAIL_LIMIT;
            r_cfg.repeat_ivl       <= RST_REPEAT_IVL;
            r_cfg.stable_thr       <= RST_STABLE_THR;
            r_cfg.min_outage       <= RST_MIN_OUTAGE;
            r_cfg.servers_distinct <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAIL_LIMIT:  r_cfg.fail_limit       <= i_cfg_data;
                CFG_REPEAT_IVL:  r_cfg.repeat_ivl       <= i_cfg_data;
                CFG_STABLE_THR:  r_cfg.stable_thr       <= i_cfg_data;
                CFG_MIN_OUTAGE:  r_cfg.min_outage       <= i_cfg_data;
                CFG_SERVERS_DST: r_cfg.servers_distinct <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // debounce state update
    lhad_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_kind   (i_s_axis_tuser),
        .i_now    (i_s_axis_tdata[31:0]),
        .i_code   (i_s_axis_tdata[33:32]),
        .i_mins   (i_s_axis_tdata[44:34]),
        .o_state  (n_state),
        .o_result (n_s1_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.outage_reported <= 1'b0;
            r_state.first_fail      <= '0;
            r_state.last_alarm      <= '0;
            r_state.stable_since    <= '0;
            r_state.pause_active    <= 1'b0;
            r_state.pause_end       <= '0;
            r_state.working         <= 1'b1;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_res <= n_s1_res;
        end
    end

    // milliseconds left to seconds
    assign div_n      = r_s1_res.pause_diff[TIME_W-1:DIV_PRE_SHIFT];
    assign div_prod   = {{DIV_M_W{1'b0}}, div_n} * {{DIV_N_W{1'b0}}, DIV_RECIP};
    assign n_out_left = div_prod[DIV_SHIFT+LEFT_W-1:DIV_SHIFT];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_alarm    <= r_s1_res.alarm;
            r_out_duration <= r_s1_res.duration;
            r_out_working  <= r_s1_res.working;
            r_out_paused   <= r_s1_res.paused;
            r_out_left     <= n_out_left;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_alarm;
    assign o_m_axis_tdata  = {7'd0, r_out_left, r_out_paused, r_out_working, r_out_duration};

    // checks on the debounce logic
    `LHAD_ASSERT_IMPL(a_pause_end_idle, i_clk, i_rst_n,
        !r_state.pause_active, r_state.pause_end == '0)
    `LHAD_ASSERT_IMPL(a_no_duration, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ALARM_NONE || o_m_axis_tuser == ALARM_CRITICAL),
        o_m_axis_tdata[31:0] == '0)
    `LHAD_ASSERT_IMPL(a_left_needs_pause, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[56:34] != '0, o_m_axis_tdata[33])
    `LHAD_ASSERT_NEXT(a_command_silent, i_clk, i_rst_n,
        in_accept && i_s_axis_tuser != KIND_PROBE, r_s1_res.alarm == ALARM_NONE)

endmodule

>>> sv/lhad_step.sv
// next-state and result logic for one word
module lhad_step import lhad_pkg::*; (
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [1:0]        i_kind,
    input  logic [TIME_W-1:0] i_now,
    input  logic [1:0]        i_code,
    input  logic [MINS_W-1:0] i_mins,
    output t_state            o_state,
    output t_result           o_result
);

    always_comb begin
        logic [MINS_W-1:0] mins_sat;
        logic [CFG_W-1:0]  pause_len;
        logic [TIME_W-1:0] ss;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] ff;
        logic [TIME_W-1:0] down;
        logic              pause_gate;
        logic              fire;
        t_state            st;
        t_result           res;

        // pause as seen mid-word, with expiry at this time applied
        pause_gate = i_state.pause_active &&
                     !(i_state.pause_end != '0 && i_now >= i_state.pause_end);

        // timed pause end
        mins_sat  = (i_mins > MAX_PAUSE_MIN) ? MAX_PAUSE_MIN : i_mins;
        pause_len = {16'd0, mins_sat} * {11'd0, MS_PER_MIN};

        // recovery window
        ss   = (i_state.stable_since == '0) ? i_now : i_state.stable_since;
        held = i_now - ss;

        // down timer and repeat spacing
        ff   = (i_state.first_fail == '0) ? i_now : i_state.first_fail;
        down = i_now - ff;
        fire = (ff != '0) && (down >= {5'd0, i_cfg.fail_limit}) &&
               ((i_state.last_alarm == '0) ||
                ((i_now - i_state.last_alarm) >= {5'd0, i_cfg.repeat_ivl}));

        st           = i_state;
        res.alarm    = ALARM_NONE;
        res.duration = '0;

        case (i_kind)
            KIND_PAUSE_TIMED: begin
                st.pause_active = 1'b1;
                st.pause_end    = i_now + {5'd0, pause_len};
            end
            KIND_PAUSE_HOLD: begin
                st.pause_active = 1'b1;
                st.pause_end    = '0;
            end
            KIND_RESUME: begin
                st.pause_active = 1'b0;
                st.pause_end    = '0;
            end
            default: begin
                if (i_code == PROBE_OK) begin
                    st.working = 1'b1;
                    if (!i_state.outage_reported) begin
                        st.stable_since = '0;
                    end else if (i_state.first_fail != '0 &&
                                 (i_now - i_state.first_fail) < {5'd0, i_cfg.min_outage}) begin
                        // short blip, dropped silently
                        st.outage_reported = 1'b0;
                        st.first_fail      = '0;
                        st.last_alarm      = '0;
                        st.stable_since    = '0;
                    end else begin
                        st.stable_since = ss;
                        if (held >= {5'd0, i_cfg.stable_thr}) begin
                            if (!pause_gate) begin
                                res.alarm    = ALARM_RECOVERED;
                                res.duration = held;
                            end
                            st.outage_reported = 1'b0;
                            st.first_fail      = '0;
                            st.last_alarm      = '0;
                            st.stable_since    = '0;
                            st.pause_active    = 1'b0;
                            st.pause_end       = '0;
                        end
                    end
                end else if (i_code == PROBE_PRI_FAIL && i_cfg.servers_distinct) begin
                    // running on fallback
                    st.working    = 1'b1;
                    st.first_fail = ff;
                    if (fire) begin
                        if (!pause_gate) begin
                            res.alarm    = ALARM_DOWN;
                            res.duration = down;
                        end
                        st.last_alarm = i_now;
                    end
                end else begin
                    // complete failure, or primary failure with one server
                    st.working      = 1'b0;
                    st.stable_since = '0;
                    if (!i_state.outage_reported) begin
                        if (i_cfg.servers_distinct) begin
                            res.alarm = ALARM_CRITICAL;
                        end
                        st.outage_reported = 1'b1;
                    end
                end
            end
        endcase

        // timed pause expiry after every word
        if (st.pause_active && st.pause_end != '0 && i_now >= st.pause_end) begin
            st.pause_active = 1'b0;
            st.pause_end    = '0;
        end

        res.working    = st.working;
        res.paused     = st.pause_active;
        res.pause_diff = (st.pause_active && st.pause_end != '0) ?
                         (st.pause_end - i_now) : '0;

        o_state  = st;
        o_result = res;
    end

endmodule

>>> bench/link_health_alarm_debouncer_core_tb.sv
// testbench for the link health alarm debouncer: directed and random words against a predictor
module link_health_alarm_debouncer_core_tb import lhad_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // one result word split into its fields
    typedef struct packed {
        logic [1:0]        alarm;
        logic [TIME_W-1:0] duration;
        logic              working;
        logic              paused;
        logic [LEFT_W-1:0] left_s;
    } t_link_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [47:0]          i_s_axis_tdata = '0;  // now_ms[31:0], probe_code[33:32],
                                                // pause_minutes[44:34], zeros
    logic [1:0]           i_s_axis_tuser = '0;  // kind[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [63:0]          o_m_axis_tdata;       // alarm_duration_ms[31:0], link_working[32],
                                                // paused_now[33], pause_left_s[56:34], zeros
    logic [1:0]           o_m_axis_tuser;       // alarm[1:0]

    link_health_alarm_debouncer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow configuration
    logic [CFG_W-1:0]  fail_limit;
    logic [CFG_W-1:0]  repeat_ivl;
    logic [CFG_W-1:0]  stable_thr;
    logic [CFG_W-1:0]  min_outage;
    logic              distinct;

    // shadow debounce state
    bit                outage_seen;
    logic [TIME_W-1:0] down_since;
    logic [TIME_W-1:0] last_alert_at;
    logic [TIME_W-1:0] healthy_since;
    bit                pause_on;
    logic [TIME_W-1:0] pause_until;
    bit                link_up;

    t_link_report      pending_reports[$];
    int unsigned       mismatch_count = 0;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    logic              rx_hold = 1'b0;
    logic [TIME_W-1:0] wall_ms = 32'd1000;
    logic [1:0]        cur_code = PROBE_OK;

    function automatic void stop_pause();
        pause_on    = 1'b0;
        pause_until = '0;
    endfunction

    // pause test with expiry
    function automatic bit pause_holds(input logic [TIME_W-1:0] now);
        if (!pause_on)
            return 1'b0;
        if (pause_until != 0 && now >= pause_until) begin
            stop_pause();
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void forget_outage();
        outage_seen   = 1'b0;
        down_since    = '0;
        last_alert_at = '0;
        healthy_since = '0;
    endfunction

    function automatic void reset_shadow();
        fail_limit = RST_FAIL_LIMIT;
        repeat_ivl = RST_REPEAT_IVL;
        stable_thr = RST_STABLE_THR;
        min_outage = RST_MIN_OUTAGE;
        distinct   = 1'b1;
        forget_outage();
        stop_pause();
        link_up = 1'b1;
    endfunction

    // expected report of one word, updates the shadow state
    function automatic t_link_report predict_report(input logic [1:0] kind,
                                                    input logic [TIME_W-1:0] now,
                                                    input logic [1:0] code,
                                                    input logic [MINS_W-1:0] mins);
        t_link_report      r;
        logic [MINS_W-1:0] m;
        logic [TIME_W-1:0] down;
        logic [TIME_W-1:0] held;
        bit                fire;
        r = '0;
        r.alarm = ALARM_NONE;
        case (kind)
            KIND_PAUSE_TIMED: begin
                m = (mins > MAX_PAUSE_MIN) ? MAX_PAUSE_MIN : mins;
                pause_on    = 1'b1;
                pause_until = now + 32'(m) * 32'(MS_PER_MIN);
            end
            KIND_PAUSE_HOLD: begin
                pause_on    = 1'b1;
                pause_until = '0;
            end
            KIND_RESUME: begin
                stop_pause();
            end
            default: begin
                if (code == PROBE_OK) begin
                    link_up = 1'b1;
                    if (!outage_seen) begin
                        healthy_since = '0;
                    end else if (down_since != 0 &&
                                 (now - down_since) < {5'd0, min_outage}) begin
                        // short outage dropped as a blip
                        forget_outage();
                    end else begin
                        if (healthy_since == 0)
                            healthy_since = now;
                        held = now - healthy_since;
                        if (held >= {5'd0, stable_thr}) begin
                            if (!pause_holds(now)) begin
                                r.alarm    = ALARM_RECOVERED;
                                r.duration = held;
                            end
                            forget_outage();
                            stop_pause();
                        end
                    end
                end else if (code == PROBE_PRI_FAIL && distinct) begin
                    link_up = 1'b1;
                    if (down_since == 0)
                        down_since = now;
                    if (down_since != 0) begin
                        down = now - down_since;
                        fire = 1'b0;
                        if (down >= {5'd0, fail_limit})
                            fire = (last_alert_at == 0) ||
                                   ((now - last_alert_at) >= {5'd0, repeat_ivl});
                        if (fire) begin
                            if (!pause_holds(now)) begin
                                r.alarm    = ALARM_DOWN;
                                r.duration = down;
                            end
                            last_alert_at = now;
                        end
                    end
                end else begin
                    // complete failure, or primary failure with one server
                    link_up       = 1'b0;
                    healthy_since = '0;
                    if (!outage_seen) begin
                        if (distinct)
                            r.alarm = ALARM_CRITICAL;
                        outage_seen = 1'b1;
                    end
                end
            end
        endcase
        void'(pause_holds(now));
        if (pause_on && pause_until != 0 && now < pause_until)
            r.left_s = LEFT_W'((pause_until - now) / 32'd1000);
        r.working = link_up;
        r.paused  = pause_on;
        return r;
    endfunction

    // send one word and record its expected report at acceptance
    task automatic send_word(input logic [1:0] kind, input logic [TIME_W-1:0] now,
                             input logic [1:0] code, input logic [MINS_W-1:0] mins);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'd0, mins, code, now};
        i_s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        pending_reports.push_back(predict_report(kind, now, code, mins));
    endtask

    // probe word shorthand
    task automatic probe(input logic [TIME_W-1:0] now, input logic [1:0] code);
        send_word(KIND_PROBE, now, code, MINS_W'($urandom_range(0, 2047)));
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all five registers while the block is idle
    task automatic apply_config(input logic [CFG_W-1:0] f, input logic [CFG_W-1:0] rp,
                                input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] mo,
                                input logic [CFG_W-1:0] dst);
        logic [CFG_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0] idx[5];
        vals = '{f, rp, st, mo, dst};
        idx  = '{CFG_FAIL_LIMIT, CFG_REPEAT_IVL, CFG_STABLE_THR, CFG_MIN_OUTAGE,
                 CFG_SERVERS_DST};
        wait_drained();
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (idx[i])
                CFG_FAIL_LIMIT: fail_limit = vals[i];
                CFG_REPEAT_IVL: repeat_ivl = vals[i];
                CFG_STABLE_THR: stable_thr = vals[i];
                CFG_MIN_OUTAGE: min_outage = vals[i];
                default:        distinct   = vals[i][0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // result side: compare each accepted word, then pick the next ready
    always @(posedge i_clk) begin : report_check
        t_link_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result word with no expectation waiting");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_m_axis_tuser !== want.alarm) begin
                    $error("alarm: expected %0d, got %0d", want.alarm, o_m_axis_tuser);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[31:0] !== want.duration) begin
                    $error("alarm_duration_ms: expected %0d, got %0d",
                           want.duration, o_m_axis_tdata[31:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[32] !== want.working) begin
                    $error("link_working: expected %0d, got %0d",
                           want.working, o_m_axis_tdata[32]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[33] !== want.paused) begin
                    $error("paused_now: expected %0d, got %0d",
                           want.paused, o_m_axis_tdata[33]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[56:34] !== want.left_s) begin
                    $error("pause_left_s: expected %0d, got %0d",
                           want.left_s, o_m_axis_tdata[56:34]);
                    mismatch_count++;
                end
            end
        end
        i_m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // down, repeat, critical, recovery and blip sequences at reset settings
    task automatic test_outage_alerts();
        probe(32'd1000, PROBE_OK);           // healthy, nothing tracked
        probe(32'd2000, PROBE_PRI_FAIL);     // down timer starts
        probe(32'd302000, PROBE_PRI_FAIL);   // first down alert
        probe(32'd302001, PROBE_PRI_FAIL);
        probe(32'd2102000, PROBE_PRI_FAIL);  // repeated down alert
        probe(32'd2102100, 2'd2);            // critical
        probe(32'd2102200, 2'd3);            // code three, already reported
        probe(32'd2200000, PROBE_OK);        // stable window opens
        probe(32'd2500000, PROBE_OK);        // recovered
        probe(32'd3000000, PROBE_PRI_FAIL);
        probe(32'd3000100, 2'd3);
        probe(32'd3010000, PROBE_OK);        // blip, dropped
        probe(32'd0, PROBE_PRI_FAIL);        // time zero reads as not tracking
        probe(32'hFFFF_FFFF, PROBE_PRI_FAIL);
        probe(32'd299999, PROBE_PRI_FAIL);   // down time across the wrap
        probe(32'd400000, PROBE_OK);         // no reported outage, timer keeps going
        probe(32'd2100000, PROBE_PRI_FAIL);
    endtask

    // pause commands, expiry, saturation and swallowed alerts
    task automatic test_pause_commands();
        send_word(KIND_PAUSE_TIMED, 32'd5000000, 2'd3, 11'd0);  // expires at once
        send_word(KIND_PAUSE_HOLD, 32'd5000100, 2'd1, 11'h7FF);
        probe(32'd6000000, PROBE_PRI_FAIL);                     // down alert swallowed
        probe(32'd6000100, 2'd2);                               // critical still raised
        send_word(KIND_RESUME, 32'd6000200, 2'd2, 11'h555);
        send_word(KIND_PAUSE_TIMED, 32'd6000300, 2'd0, 11'h7FF); // saturates
        probe(32'd6000400, PROBE_OK);
        probe(32'd6300400, PROBE_OK);                           // recovered swallowed
        send_word(KIND_PAUSE_TIMED, 32'd7000000, 2'd0, 11'd1);
        probe(32'd7030000, PROBE_PRI_FAIL);
        probe(32'd7060000, PROBE_OK);                           // pause ends here
        send_word(KIND_PAUSE_TIMED, 32'hFFFF_15A0, 2'd1, 11'd1); // end wraps to zero
        probe(32'hFFFF_F000, PROBE_OK);
        send_word(KIND_RESUME, 32'hFFFF_FF00, 2'd0, 11'd0);
        send_word(KIND_PAUSE_TIMED, 32'hFFFF_FFFF, 2'd2, 11'd1440);
        send_word(KIND_PAUSE_TIMED, 32'd8000000, 2'd1, 11'd1441);
        send_word(KIND_RESUME, 32'd8000001, 2'd3, 11'd2);
    endtask

    // one server only: primary failure counts as complete failure, no critical
    task automatic test_single_server();
        apply_config(RST_FAIL_LIMIT, RST_REPEAT_IVL, RST_STABLE_THR, RST_MIN_OUTAGE,
                     27'h2AAAAAA);
        probe(32'd9000000, PROBE_PRI_FAIL);
        probe(32'd9000100, 2'd2);
        probe(32'd9100000, PROBE_OK);
        probe(32'd9500000, PROBE_OK);
        apply_config(RST_FAIL_LIMIT, RST_REPEAT_IVL, RST_STABLE_THR, RST_MIN_OUTAGE,
                     27'h5555555);
        probe(32'd9600000, PROBE_PRI_FAIL);
    endtask

    // random words with persistent probe outcomes
    task automatic run_random_words(input int n_words);
        int unsigned step_max;
        int unsigned mins_small;
        int          r;
        logic [MINS_W-1:0] mins;
        step_max = fail_limit;
        if (stable_thr > step_max)
            step_max = stable_thr;
        step_max = step_max / 3 + 1000;
        mins_small = step_max * 6 / 60000 + 1;
        if (mins_small > 2047)
            mins_small = 2047;
        for (int i = 0; i < n_words; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                wall_ms = $urandom;
            else if (r > 4)
                wall_ms = wall_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 99) < 15) begin
                r = $urandom_range(0, 99);
                cur_code = (r < 45) ? PROBE_OK : (r < 80) ? PROBE_PRI_FAIL :
                           (r < 95) ? 2'd2 : 2'd3;
            end
            mins = ($urandom_range(0, 3) == 0) ? MINS_W'($urandom_range(0, 2047)) :
                                                 MINS_W'($urandom_range(0, mins_small));
            r = $urandom_range(0, 99);
            if (r < 6)
                send_word(KIND_PAUSE_TIMED, wall_ms, 2'($urandom), mins);
            else if (r < 8)
                send_word(KIND_PAUSE_HOLD, wall_ms, 2'($urandom), mins);
            else if (r < 12)
                send_word(KIND_RESUME, wall_ms, 2'($urandom), mins);
            else
                send_word(KIND_PROBE, wall_ms, cur_code, mins);
        end
    endtask

    // several settings, extremes among them, each under one idle pattern
    task automatic test_random_traffic();
        int tx_pcts[4] = '{0, 57, 0, 35};
        int rx_pcts[4] = '{0, 0, 57, 35};
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_config(RST_FAIL_LIMIT, RST_REPEAT_IVL, RST_STABLE_THR,
                                RST_MIN_OUTAGE, 27'd1);
                1: apply_config(27'd30000, 27'd60000, 27'd30000, 27'd5000, 27'd1);
                2: apply_config(27'd86400000, 27'd86400000, 27'd86400000,
                                27'd86400000, 27'd1);
                4: apply_config(27'd0, 27'h7FFFFFF, 27'($urandom), 27'd0, 27'd1);
                5: apply_config(27'd30000, 27'd60000, 27'd30000, 27'd5000, 27'd0);
                7: apply_config(27'd30000, 27'd86400000, 27'd86400000, 27'd5000,
                                27'($urandom));
                default: apply_config(27'($urandom_range(30000, 2000000)),
                                      27'($urandom_range(60000, 4000000)),
                                      27'($urandom_range(30000, 2000000)),
                                      27'($urandom_range(5000, 500000)),
                                      27'($urandom_range(0, 1)));
            endcase
            tx_idle_pct = tx_pcts[p % 4];
            rx_stall_pct <= rx_pcts[p % 4];
            run_random_words(100);
        end
    endtask

    // long receiver hold while words keep coming
    task automatic test_backpressure();
        apply_config(27'd30000, 27'd60000, 27'd30000, 27'd5000, 27'd1);
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            run_random_words(40);
        join
    endtask

    initial begin
        reset_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_outage_alerts();
        test_pause_commands();
        test_single_server();
        test_backpressure();
        test_random_traffic();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
